@@ hw/rtl/ctgi_pkg.sv @@
// Package for the circuit table unit: opcodes, status codes, sequencer states
// and the stored peer record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctgi_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_MATCH  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } state_t;

  typedef struct packed {
    logic [7:0]  index;
    logic [7:0]  id;
    logic [55:0] user;
    logic [55:0] node;
  } peer_t;

endpackage

`default_nettype wire

@@ hw/rtl/circuit_table_with_generation_ids_unit.sv @@
// Circuit table with per-slot generation IDs: allocate, free, lookup, match.
// Depends on ctgi_pkg.
// Allocate and match scan one slot per cycle from slot 0, stopping at a hit
// or at the last slot; free and lookup read only the addressed slot, and an
// out-of-range free or lookup skips the scan. One word in flight: in_ready is
// low until the result leaves the sequencer. The scan rate is set by the single
// read port of the peer and generation memories. Synchronous reset marks every
// slot free with ID 0 at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module circuit_table_with_generation_ids_unit
  import ctgi_pkg::*;
#(
  parameter int NUM_SLOTS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [7:0]  in_circuit_index,
  input  wire logic [7:0]  in_circuit_id,
  input  wire logic [55:0] in_peer_user,
  input  wire logic [55:0] in_peer_node,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [7:0]       out_slot_index,
  output logic [7:0]       out_slot_id
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(NUM_SLOTS - 1);
  localparam logic [8:0] SlotCnt = 9'(NUM_SLOTS);

  // memories
  logic [7:0] gen_mem  [NUM_SLOTS];
  peer_t      peer_mem [NUM_SLOTS];

  state_t state_r, state_nxt;
  opcode_t op_r, op_nxt;
  peer_t key_r, key_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic issue_r, issue_nxt;
  logic p_vld_r, p_vld_nxt;
  logic [IW-1:0] p_idx_r, p_idx_nxt;
  logic p_open_r, p_open_nxt;
  logic p_last_r, p_last_nxt;
  logic [7:0] gen_rd_r;
  logic gvld_rd_r;
  peer_t peer_rd_r;
  status_t res_status_r, res_status_nxt;
  logic [7:0] res_idx_r, res_idx_nxt;
  logic [7:0] res_id_r, res_id_nxt;
  logic out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  logic [7:0] out_idx_r, out_idx_nxt;
  logic [7:0] out_id_r, out_id_nxt;
  logic [NUM_SLOTS-1:0] open_r, open_nxt;
  logic [NUM_SLOTS-1:0] gen_vld_r, gen_vld_nxt;

  logic in_acc, in_range, in_single, single, out_load, finish, hit;
  logic gen_we, peer_we;
  logic [7:0] gen_cur, gen_inc;
  opcode_t in_op;
  status_t ev_status;
  logic [7:0] ev_idx, ev_id;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign in_op     = opcode_t'(in_opcode);
  assign in_single = (in_op == OP_FREE) || (in_op == OP_LOOKUP);
  assign in_range  = ({1'b0, in_circuit_index} < SlotCnt);
  assign single    = (op_r == OP_FREE) || (op_r == OP_LOOKUP);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign gen_cur   = gvld_rd_r ? gen_rd_r : 8'd0;
  assign gen_inc   = gen_cur + 8'd1;
  assign finish    = p_vld_r && (hit || p_last_r);

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_idx_r;
  assign out_slot_id    = out_id_r;

  // evaluate the slot read last cycle
  always_comb begin
    hit       = 1'b0;
    ev_status = ST_NOMATCH;
    ev_idx    = 8'd0;
    ev_id     = 8'd0;
    case (op_r)
      OP_ALLOC: begin
        hit = !p_open_r;
        if (hit) begin
          ev_status = ST_OK;
          ev_idx    = 8'(p_idx_r);
          ev_id     = gen_cur;
        end else begin
          ev_status = ST_FULL;
        end
      end
      OP_FREE: begin
        hit = p_open_r;
        if (hit) begin
          ev_status = ST_OK;
          ev_idx    = 8'(p_idx_r);
          ev_id     = gen_inc;
        end else begin
          ev_status = ST_BADFREE;
          ev_idx    = key_r.index;
        end
      end
      OP_LOOKUP: begin
        hit = p_open_r && (gen_cur == key_r.id);
        if (hit) begin
          ev_status = ST_OK;
          ev_idx    = 8'(p_idx_r);
          ev_id     = gen_cur;
        end else begin
          ev_idx = key_r.index;
        end
      end
      OP_MATCH: begin
        hit = p_open_r && (peer_rd_r == key_r);
        if (hit) begin
          ev_status = ST_OK;
          ev_idx    = 8'(p_idx_r);
          ev_id     = gen_cur;
        end
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_single && !in_range) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (finish) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_nxt         = op_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    issue_nxt      = issue_r;
    p_vld_nxt      = 1'b0;
    p_idx_nxt      = p_idx_r;
    p_open_nxt     = p_open_r;
    p_last_nxt     = p_last_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_id_nxt     = res_id_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_id_nxt     = out_id_r;
    open_nxt       = open_r;
    gen_vld_nxt    = gen_vld_r;
    gen_we         = 1'b0;
    peer_we        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_op;
          key_nxt   = '{index: in_circuit_index, id: in_circuit_id,
                        user: in_peer_user, node: in_peer_node};
          idx_nxt   = in_single ? in_circuit_index[IW-1:0] : '0;
          issue_nxt = !in_single || in_range;
          res_status_nxt = (in_op == OP_FREE) ? ST_BADFREE : ST_NOMATCH;
          res_idx_nxt    = in_circuit_index;
          res_id_nxt     = 8'd0;
        end
      end
      S_SCAN: begin
        if (issue_r) begin
          p_vld_nxt  = 1'b1;
          p_idx_nxt  = idx_r;
          p_open_nxt = open_r[idx_r];
          p_last_nxt = single || (idx_r == LastIdx);
          if (p_last_nxt) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        if (finish) begin
          issue_nxt      = 1'b0;
          p_vld_nxt      = 1'b0;
          res_status_nxt = ev_status;
          res_idx_nxt    = ev_idx;
          res_id_nxt     = ev_id;
          if (hit && (op_r == OP_ALLOC)) begin
            peer_we           = 1'b1;
            open_nxt[p_idx_r] = 1'b1;
          end
          if (hit && (op_r == OP_FREE)) begin
            gen_we               = 1'b1;
            open_nxt[p_idx_r]    = 1'b0;
            gen_vld_nxt[p_idx_r] = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_idx_nxt    = res_idx_r;
          out_id_nxt     = res_id_r;
        end
      end
      default: begin
        issue_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_r     <= 1'b0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
      open_r      <= '0;
      gen_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      p_vld_r     <= p_vld_nxt;
      out_valid_r <= out_valid_nxt;
      open_r      <= open_nxt;
      gen_vld_r   <= gen_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    p_idx_r      <= p_idx_nxt;
    p_open_r     <= p_open_nxt;
    p_last_r     <= p_last_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_id_r     <= res_id_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_id_r     <= out_id_nxt;
  end

  // single read port at the scan pointer, write at the evaluated slot
  always_ff @(posedge clk) begin
    gen_rd_r  <= gen_mem[idx_r];
    peer_rd_r <= peer_mem[idx_r];
    gvld_rd_r <= gen_vld_r[idx_r];
    if (gen_we) begin
      gen_mem[p_idx_r] <= gen_inc;
    end
    if (peer_we) begin
      peer_mem[p_idx_r] <= key_r;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ctgi_checker.sv @@
// Port-level checks for circuit_table_with_generation_ids_unit, bound to it.
// Depends on ctgi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctgi_checker
  import ctgi_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [7:0]  out_slot_index,
  input wire logic [7:0]  out_slot_id
);

  // held word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_slot_index) && $stable(out_slot_id))
    else $error("result word changed while stalled");

  // one word at a time: busy right after accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a word while busy");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_slot_index == 8'd0) &&
      (out_slot_id == 8'd0))
    else $error("table full result carries a slot");

  a_badfree_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_BADFREE) |-> (out_slot_id == 8'd0))
    else $error("bad free result carries an ID");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind circuit_table_with_generation_ids_unit ctgi_checker u_ctgi_checker (.*);

`default_nettype wire
